### rtl/pip_pkg.sv
// ----------------------------------------------------------------------------
// pip_pkg: shared types and constants of the point-in-polygon test unit
//
// Function codes, sequencer states, the chunk width of the shared multiplier
// and the control and status bundles between the sequencer and the
// crossing unit.
// ----------------------------------------------------------------------------
package pip_pkg;

   // Field widths fixed by the interface.
   localparam int VCOUNT_WIDTH = 7;
   localparam int VINDEX_WIDTH = 6;

   // Width of the multiplier digit that the crossing unit consumes per cycle.
   localparam int CHUNK_WIDTH = 16;

   // Function codes of an input beat.
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_TEST = 1'b1;

   // Sequencer states of the top level.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SETUP,
      ST_MUL,
      ST_RESULT
   } pip_state_type;

   // Start command and operand signs for one edge crossing test.
   typedef struct packed {
      logic start;
      logic lhs_neg;
      logic rhs_neg;
      logic d_pos;
   } pip_mac_ctrl_type;

   // Completion pulse and verdict of one edge crossing test.
   typedef struct packed {
      logic done;
      logic crosses;
   } pip_mac_stat_type;

endpackage

### rtl/pip_cross_unit.sv
// ----------------------------------------------------------------------------
// pip_cross_unit: iterative exact edge crossing test
//
// Computes the sign of lhs - rhs, where lhs and rhs are products of two
// coordinate differences given as magnitudes and signs. One multiplier of
// COORD_WIDTH by CHUNK_WIDTH bits is reused over the digits of both products;
// each partial product is registered and then added into one accumulator.
// ----------------------------------------------------------------------------
module pip_cross_unit #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pip_pkg::pip_mac_ctrl_type     ctrl,
   input  logic [COORD_WIDTH-1:0]        lhs_a,
   input  logic [COORD_WIDTH-1:0]        lhs_b,
   input  logic [COORD_WIDTH-1:0]        rhs_a,
   input  logic [COORD_WIDTH-1:0]        rhs_b,
   output pip_pkg::pip_mac_stat_type     status
);

   localparam int CHW    = pip_pkg::CHUNK_WIDTH;
   localparam int NCHUNK = (COORD_WIDTH + CHW - 1) / CHW;
   localparam int PADW   = NCHUNK * CHW;
   localparam int CKW    = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
   localparam int PPW    = COORD_WIDTH + CHW;
   localparam int ACCW   = 2 * COORD_WIDTH + 2;
   localparam logic [CKW-1:0] LAST_CHUNK = CKW'(NCHUNK - 1);

   // Control state.
   logic             busy_ff, busy_in;
   logic             sel_ff;
   logic [CKW-1:0]   chunk_ff;
   logic             pp_valid_ff, pp_valid_in;
   logic             pp_last_ff;
   logic             fin_ff, fin_in;

   // Operands and datapath.
   logic [COORD_WIDTH-1:0] lhs_a_ff, rhs_a_ff, rhs_b_ff;
   logic [PADW-1:0]        b_sh_ff;
   logic                   lhs_neg_ff, rhs_neg_ff, d_pos_ff;
   logic [PPW-1:0]         pp_ff;
   logic [CKW-1:0]         pp_chunk_ff;
   logic                   pp_neg_ff;
   logic signed [ACCW-1:0] acc_ff;

   logic [COORD_WIDTH-1:0] mul_a;
   logic [PPW-1:0]         mul_p;
   logic [ACCW-1:0]        term;
   logic                   last_step;

   // One digit product per busy cycle: the first product, then the second.
   assign mul_a     = sel_ff ? rhs_a_ff : lhs_a_ff;
   assign mul_p     = PPW'(mul_a) * PPW'(b_sh_ff[CHW-1:0]);
   assign last_step = busy_ff && sel_ff && (chunk_ff == LAST_CHUNK);

   // Registered partial product aligned to its digit position.
   assign term = ACCW'(pp_ff) << (pp_chunk_ff * CHW);

   // Control next values.
   always_comb begin
      busy_in     = busy_ff;
      pp_valid_in = busy_ff;
      fin_in      = pp_valid_ff && pp_last_ff;
      if (ctrl.start) begin
         busy_in = 1'b1;
      end else if (last_step) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         pp_valid_ff <= 1'b0;
         fin_ff      <= 1'b0;
      end else begin
         busy_ff     <= busy_in;
         pp_valid_ff <= pp_valid_in;
         fin_ff      <= fin_in;
      end
   end

   // Operand capture and digit walk.
   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         lhs_a_ff   <= lhs_a;
         rhs_a_ff   <= rhs_a;
         rhs_b_ff   <= rhs_b;
         b_sh_ff    <= PADW'(lhs_b);
         lhs_neg_ff <= ctrl.lhs_neg;
         rhs_neg_ff <= ctrl.rhs_neg;
         d_pos_ff   <= ctrl.d_pos;
         sel_ff     <= 1'b0;
         chunk_ff   <= '0;
      end else if (busy_ff) begin
         if (chunk_ff == LAST_CHUNK) begin
            sel_ff   <= 1'b1;
            chunk_ff <= '0;
            b_sh_ff  <= PADW'(rhs_b_ff);
         end else begin
            chunk_ff <= chunk_ff + 1'b1;
            b_sh_ff  <= b_sh_ff >> CHW;
         end
      end
   end

   // Partial product register. The second product enters with negated sign.
   always_ff @(posedge clock) begin
      pp_ff       <= mul_p;
      pp_chunk_ff <= chunk_ff;
      pp_neg_ff   <= sel_ff ? !rhs_neg_ff : lhs_neg_ff;
      pp_last_ff  <= last_step;
   end

   // Accumulator of lhs - rhs.
   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         acc_ff <= '0;
      end else if (pp_valid_ff) begin
         acc_ff <= pp_neg_ff ? (acc_ff - $signed(term)) : (acc_ff + $signed(term));
      end
   end

   // The edge counts when lhs < rhs for a rising edge, lhs > rhs otherwise.
   assign status.done    = fin_ff;
   assign status.crosses = d_pos_ff ? acc_ff[ACCW-1]
                                    : (!acc_ff[ACCW-1] && (acc_ff != '0));

   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      ctrl.start |-> (!busy_ff && !pp_valid_ff && !fin_ff))
      else $error("crossing unit started while a test was in flight");

   a_done_after_drain: assert property (@(posedge clock) disable iff (reset)
      status.done |-> (!busy_ff && !pp_valid_ff))
      else $error("crossing verdict given before all digits were added");

   a_done_follows_last: assert property (@(posedge clock) disable iff (reset)
      last_step |=> ##1 status.done)
      else $error("crossing verdict missing after the last digit");

endmodule

### rtl/point_in_polygon_test_unit.sv
// ----------------------------------------------------------------------------
// point_in_polygon_test_unit: even-odd ray crossing test against a polygon
//
// Load beats write one vertex into the vertex memory. Test beats walk the
// edges of the stored ring and toggle a parity for every edge that straddles
// the query y and crosses strictly left of the query x, using an exact
// cross-multiplied compare in a shared digit-serial crossing unit.
//
//   channel  ports                               direction  handshake
//   req      req_func, req_vertex_index,          in         req_valid/req_stall
//            req_point_x, req_point_y
//   rsp      rsp_inside_res                      out        rsp_valid/rsp_stall
//   csr      csr_wr_data (vertex_count)          in         csr_wr_en
//
// The time to a result beat grows with the vertices in use and with the
// straddling edges; each straddling edge runs two products of C =
// ceil(COORD_WIDTH/16) digits each (C = 2 at 32 bits) through the crossing
// unit's multiplier, and every vertex passes through the vertex memory read.
// With no vertices in use the sequencer goes straight to the result.
// req_stall is high from acceptance of a test beat until its parity enters
// the output register. While a result waits there, loads and one more test
// are taken; a second finished test holds req_stall high until the first
// result is taken. A stalled result holds. Reset clears the sequencer, the
// output valid flag and vertex_count; the vertex memory is not cleared and
// must be written before it is used.
// ----------------------------------------------------------------------------
module point_in_polygon_test_unit #(
   parameter int MAX_VERTICES = 64,
   parameter int COORD_WIDTH  = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_func,
   input  logic [pip_pkg::VINDEX_WIDTH-1:0]     req_vertex_index,
   input  logic signed [COORD_WIDTH-1:0]        req_point_x,
   input  logic signed [COORD_WIDTH-1:0]        req_point_y,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_inside_res,
   input  logic                                 csr_wr_en,
   input  logic [pip_pkg::VCOUNT_WIDTH-1:0]     csr_wr_data
);

   localparam int AW = $clog2(MAX_VERTICES);
   localparam int NW = (AW + 1 > pip_pkg::VCOUNT_WIDTH) ? AW + 1 : pip_pkg::VCOUNT_WIDTH;

   // Magnitude of p - q; the difference never reaches -2^COORD_WIDTH.
   function automatic logic [COORD_WIDTH-1:0] diff_mag(
      input logic signed [COORD_WIDTH-1:0] p,
      input logic signed [COORD_WIDTH-1:0] q
   );
      logic signed [COORD_WIDTH:0] d;
      d = (COORD_WIDTH + 1)'(p) - (COORD_WIDTH + 1)'(q);
      if (d[COORD_WIDTH]) begin
         d = -d;
      end
      return d[COORD_WIDTH-1:0];
   endfunction

   pip_pkg::pip_state_type state_ff, state_in;

   logic [pip_pkg::VCOUNT_WIDTH-1:0] count_ff;
   logic                             first_ff;
   logic                             parity_ff;
   logic [AW-1:0]                    idx_ff, last_ff, rd_addr_ff;
   logic signed [COORD_WIDTH-1:0]    qx_ff, qy_ff, xj_ff, yj_ff, rd_x_ff, rd_y_ff;
   logic                             out_valid_ff, out_valid_in;
   logic                             out_res_ff;

   // Vertex memory: one write port, one registered read port.
   logic signed [COORD_WIDTH-1:0]    vx_mem [MAX_VERTICES];
   logic signed [COORD_WIDTH-1:0]    vy_mem [MAX_VERTICES];

   logic                        req_accept;
   logic                        slot_ok;
   logic [NW-1:0]               count_ext, n_clamp;
   logic                        at_last;
   logic                        straddle;
   logic                        advance;
   logic                        flip;
   logic                        out_free;
   pip_pkg::pip_mac_ctrl_type   mac_ctrl;
   pip_pkg::pip_mac_stat_type   mac_stat;
   logic [COORD_WIDTH-1:0]      lhs_a, lhs_b, rhs_a, rhs_b;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != pip_pkg::ST_IDLE);
   assign rsp_valid  = out_valid_ff;
   assign rsp_inside_res = out_res_ff;

   // The output register can take a parity when it is empty or being emptied.
   assign out_free = !out_valid_ff || !rsp_stall;

   // Vertices in use, limited to the memory depth.
   assign count_ext = NW'(count_ff);
   assign n_clamp   = (count_ext > NW'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : count_ext;
   assign slot_ok   = (32'(req_vertex_index) < 32'(MAX_VERTICES));
   assign at_last   = (idx_ff == last_ff);

   // Edge from vertex i (memory output) to the previous vertex j.
   assign straddle = ((rd_y_ff < qy_ff) && (yj_ff >= qy_ff)) ||
                     ((yj_ff < qy_ff) && (rd_y_ff >= qy_ff));
   assign lhs_a = diff_mag(qy_ff, rd_y_ff);
   assign lhs_b = diff_mag(xj_ff, rd_x_ff);
   assign rhs_a = diff_mag(qx_ff, rd_x_ff);
   assign rhs_b = diff_mag(yj_ff, rd_y_ff);

   // Sequencer: next state and strobes.
   always_comb begin
      state_in = state_ff;
      advance  = 1'b0;
      flip     = 1'b0;
      out_valid_in     = out_valid_ff && rsp_stall;
      mac_ctrl.start   = 1'b0;
      mac_ctrl.lhs_neg = (qy_ff < rd_y_ff) ^ (xj_ff < rd_x_ff);
      mac_ctrl.rhs_neg = (qx_ff < rd_x_ff) ^ (yj_ff < rd_y_ff);
      mac_ctrl.d_pos   = (yj_ff > rd_y_ff);
      unique case (state_ff)
         pip_pkg::ST_IDLE: begin
            if (req_accept && (req_func == pip_pkg::FUNC_TEST)) begin
               state_in = (n_clamp == '0) ? pip_pkg::ST_RESULT : pip_pkg::ST_READ;
            end
         end
         pip_pkg::ST_READ: begin
            state_in = pip_pkg::ST_SETUP;
         end
         pip_pkg::ST_SETUP: begin
            if (first_ff) begin
               state_in = pip_pkg::ST_READ;
            end else if (straddle) begin
               mac_ctrl.start = 1'b1;
               state_in = pip_pkg::ST_MUL;
            end else begin
               advance  = 1'b1;
               state_in = at_last ? pip_pkg::ST_RESULT : pip_pkg::ST_READ;
            end
         end
         pip_pkg::ST_MUL: begin
            if (mac_stat.done) begin
               advance  = 1'b1;
               flip     = mac_stat.crosses;
               state_in = at_last ? pip_pkg::ST_RESULT : pip_pkg::ST_READ;
            end
         end
         pip_pkg::ST_RESULT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               state_in     = pip_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pip_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pip_pkg::ST_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            count_ff <= csr_wr_data;
         end
      end
   end

   // Result register: the finished parity moves here and waits for the receiver.
   always_ff @(posedge clock) begin
      if ((state_ff == pip_pkg::ST_RESULT) && out_free) begin
         out_res_ff <= parity_ff;
      end
   end

   // Walk registers: query point, previous vertex, indexes and parity.
   always_ff @(posedge clock) begin
      if (state_ff == pip_pkg::ST_IDLE) begin
         if (req_accept && (req_func == pip_pkg::FUNC_TEST)) begin
            qx_ff      <= req_point_x;
            qy_ff      <= req_point_y;
            parity_ff  <= 1'b0;
            first_ff   <= 1'b1;
            idx_ff     <= '0;
            last_ff    <= AW'(n_clamp - 1'b1);
            rd_addr_ff <= AW'(n_clamp - 1'b1);
         end
      end else if ((state_ff == pip_pkg::ST_SETUP) && first_ff) begin
         xj_ff      <= rd_x_ff;
         yj_ff      <= rd_y_ff;
         first_ff   <= 1'b0;
         rd_addr_ff <= '0;
      end else begin
         if (flip) begin
            parity_ff <= !parity_ff;
         end
         if (advance && !at_last) begin
            xj_ff      <= rd_x_ff;
            yj_ff      <= rd_y_ff;
            idx_ff     <= idx_ff + 1'b1;
            rd_addr_ff <= idx_ff + 1'b1;
         end
      end
   end

   // Vertex memory access.
   always_ff @(posedge clock) begin
      if (req_accept && (req_func == pip_pkg::FUNC_LOAD) && slot_ok) begin
         vx_mem[AW'(req_vertex_index)] <= req_point_x;
         vy_mem[AW'(req_vertex_index)] <= req_point_y;
      end
      if (state_ff == pip_pkg::ST_READ) begin
         rd_x_ff <= vx_mem[rd_addr_ff];
         rd_y_ff <= vy_mem[rd_addr_ff];
      end
   end

   // Shared exact crossing compare.
   pip_cross_unit #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_cross (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (mac_ctrl),
      .lhs_a  (lhs_a),
      .lhs_b  (lhs_b),
      .rhs_a  (rhs_a),
      .rhs_b  (rhs_b),
      .status (mac_stat)
   );

   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_inside_res)))
      else $error("stalled result beat changed or vanished");

   a_free_after_result: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == pip_pkg::ST_RESULT) && (!rsp_valid || !rsp_stall))
         |=> (!req_stall && rsp_valid))
      else $error("finished parity did not move to the output register");

   a_index_in_ring: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == pip_pkg::ST_SETUP) && !first_ff) |-> (idx_ff <= last_ff))
      else $error("edge walk ran past the last vertex");

   a_verdict_only_in_mul: assert property (@(posedge clock) disable iff (reset)
      mac_stat.done |-> (state_ff == pip_pkg::ST_MUL))
      else $error("crossing verdict arrived outside the multiply phase");

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the point-in-polygon test unit
//
// Loads vertex rings of many sizes and shapes, from tiny grids with many ties
// up to full-range coordinates, then fires query points at them. A scoreboard
// keeps its own vertex table and count, predicts the even-odd parity of every
// accepted test beat with exact wide products, and checks each result beat in
// order. Both channels idle and stall at random, with one long receiver
// hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb;

   localparam int COORD_W   = 32;
   localparam int MAX_VTX   = 64;
   localparam int DRAIN_CYC = 16;
   localparam int HOLD_CYC  = 300;

   localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
   localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] ONE   = 32'sh0001_0000;

   logic                                 clock;
   logic                                 reset;
   logic                                 req_valid;
   logic                                 req_stall;
   logic                                 req_func;
   logic [pip_pkg::VINDEX_WIDTH-1:0]     req_vertex_index;
   logic signed [COORD_W-1:0]            req_point_x;
   logic signed [COORD_W-1:0]            req_point_y;
   logic                                 rsp_valid;
   logic                                 rsp_stall;
   logic                                 rsp_inside_res;
   logic                                 csr_wr_en;
   logic [pip_pkg::VCOUNT_WIDTH-1:0]     csr_wr_data;

   int send_idle_pct;
   int rcv_idle_pct;
   bit hold_request;

   // Scoreboard: mirrors the vertex table and count, predicts each parity.
   class inside_scoreboard;
      logic signed [COORD_W-1:0] vx [MAX_VTX];
      logic signed [COORD_W-1:0] vy [MAX_VTX];
      int unsigned               count_reg;
      bit                        expected_inside_q [$];
      int                        errors;

      function new();
         count_reg = 0;
         errors    = 0;
      endfunction

      function void set_count(int unsigned value);
         count_reg = value;
      endfunction

      function int pending();
         return expected_inside_q.size();
      endfunction

      function void flag(string msg);
         errors++;
         if (errors <= 10) begin
            $display("%0t ERROR: %s", $time, msg);
         end
      endfunction

      // Even-odd ray crossing with exact cross-multiplied compares.
      function bit crossing_parity(logic signed [COORD_W-1:0] qx,
                                   logic signed [COORD_W-1:0] qy);
         int unsigned               n;
         int unsigned               j;
         logic signed [COORD_W-1:0] xi, yi, xj, yj;
         logic signed [127:0]       dy, ex, dx, d, lhs, rhs;
         bit                        odd;
         bit                        straddle;
         n   = (count_reg < MAX_VTX) ? count_reg : MAX_VTX;
         odd = 1'b0;
         if (n == 0) begin
            return 1'b0;
         end
         j = n - 1;
         for (int unsigned i = 0; i < n; i++) begin
            xi = vx[i];
            yi = vy[i];
            xj = vx[j];
            yj = vy[j];
            straddle = (yi < qy && yj >= qy) || (yj < qy && yi >= qy);
            if (straddle) begin
               dy  = 128'(qy) - 128'(yi);
               ex  = 128'(xj) - 128'(xi);
               dx  = 128'(qx) - 128'(xi);
               d   = 128'(yj) - 128'(yi);
               lhs = dy * ex;
               rhs = dx * d;
               if ((d > 0) ? (lhs < rhs) : (rhs < lhs)) begin
                  odd = ~odd;
               end
            end
            j = i;
         end
         return odd;
      endfunction

      // Called for every accepted request beat.
      function void note_beat(logic f, logic [pip_pkg::VINDEX_WIDTH-1:0] idx,
                              logic signed [COORD_W-1:0] x,
                              logic signed [COORD_W-1:0] y);
         if (f == pip_pkg::FUNC_LOAD) begin
            vx[idx] = x;
            vy[idx] = y;
         end else begin
            expected_inside_q = {expected_inside_q, crossing_parity(x, y)};
         end
      endfunction

      // Called for every accepted result beat.
      function void check_result(logic actual);
         bit exp_inside;
         if (expected_inside_q.size() == 0) begin
            flag($sformatf("unexpected result beat, inside_res %0b", actual));
            return;
         end
         exp_inside = expected_inside_q.pop_front();
         if (actual !== exp_inside) begin
            flag($sformatf("inside_res expected %0b got %0b", exp_inside, actual));
         end
      endfunction
   endclass

   inside_scoreboard sb = new();

   point_in_polygon_test_unit #(
      .MAX_VERTICES (MAX_VTX),
      .COORD_WIDTH  (COORD_W)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_vertex_index (req_vertex_index),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_inside_res   (rsp_inside_res),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard limit on the run time.
   initial begin
      #20ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Result side: check accepted beats, then pick the stall for the next edge.
   initial begin : rsp_side
      int hold_left;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            sb.check_result(rsp_inside_res);
         end
         if (hold_request) begin
            hold_left    = HOLD_CYC;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
         end
      end
   end

   // Coordinate in one of several flavors: grid, full range, extremes, fine grid.
   function automatic logic signed [COORD_W-1:0] rand_coord(int mode);
      logic signed [COORD_W-1:0] v;
      case (mode)
         0: v = 32'(($urandom_range(16) - 8) << 16);
         1: v = $urandom();
         2: begin
            case ($urandom_range(5))
               0: v = C_MIN;
               1: v = C_MAX;
               2: v = '0;
               3: v = '1;
               4: v = 32'sd1;
               default: v = ONE;
            endcase
         end
         default: v = 32'(($urandom_range(64) - 32) << 14) + 32'($urandom_range(3));
      endcase
      return v;
   endfunction

   // Offer one request beat and wait until it is taken.
   task automatic send_item(input logic f, input logic [pip_pkg::VINDEX_WIDTH-1:0] idx,
                            input logic signed [COORD_W-1:0] x,
                            input logic signed [COORD_W-1:0] y);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_func         <= f;
      req_vertex_index <= idx;
      req_point_x      <= x;
      req_point_y      <= y;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_beat(f, idx, x, y);
   endtask

   // Stop offering and let every expected result come back, then settle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYC) @(posedge clock);
   endtask

   // Write the vertex count register; the block is idle here.
   task automatic write_count(input int unsigned value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= pip_pkg::VCOUNT_WIDTH'(value);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.set_count(value);
   endtask

   // Main stimulus.
   initial begin : stim
      int unsigned counts [15];
      int unsigned cnt;
      int unsigned n;
      int          shape;
      int          r;
      int          w;
      logic signed [COORD_W-1:0] qx, qy;

      counts = '{3, 64, 0, 5, 127, 1, 4, 2, 65, 8, 6, 16, 3, 10, 7};

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_func         = pip_pkg::FUNC_LOAD;
      req_vertex_index = '0;
      req_point_x      = '0;
      req_point_y      = '0;
      csr_wr_en        = 1'b0;
      csr_wr_data      = '0;
      send_idle_pct    = 0;
      rcv_idle_pct     = 0;
      hold_request     = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty polygon straight out of reset.
      send_item(pip_pkg::FUNC_TEST, '0, '0, '0);

      // Unit square, plus a load into the top slot.
      send_item(pip_pkg::FUNC_LOAD, 6'd0, -ONE, -ONE);
      send_item(pip_pkg::FUNC_LOAD, 6'd1,  ONE, -ONE);
      send_item(pip_pkg::FUNC_LOAD, 6'd2,  ONE,  ONE);
      send_item(pip_pkg::FUNC_LOAD, 6'd3, -ONE,  ONE);
      send_item(pip_pkg::FUNC_LOAD, 6'd63, C_MAX, C_MIN);
      wait_idle();
      write_count(4);
      send_item(pip_pkg::FUNC_TEST, 6'd0, '0, '0);
      send_item(pip_pkg::FUNC_TEST, 6'd63, -ONE, '0);
      send_item(pip_pkg::FUNC_TEST, 6'd0, ONE, '0);
      send_item(pip_pkg::FUNC_TEST, 6'd0, '0, ONE);
      send_item(pip_pkg::FUNC_TEST, 6'd0, '0, -ONE);
      send_item(pip_pkg::FUNC_TEST, 6'd0, C_MAX, '0);
      send_item(pip_pkg::FUNC_TEST, 6'd0, C_MIN, C_MAX);
      send_item(pip_pkg::FUNC_TEST, 6'd0, C_MAX, C_MIN);

      // Full-range triangle stresses the widest products.
      send_item(pip_pkg::FUNC_LOAD, 6'd0, C_MIN, C_MIN);
      send_item(pip_pkg::FUNC_LOAD, 6'd1, C_MAX, '0);
      send_item(pip_pkg::FUNC_LOAD, 6'd2, '0, C_MAX);
      wait_idle();
      write_count(3);
      send_item(pip_pkg::FUNC_TEST, 6'd0, '0, '0);
      send_item(pip_pkg::FUNC_TEST, 6'd0, C_MAX, C_MAX);
      send_item(pip_pkg::FUNC_TEST, 6'd0, C_MIN, C_MIN);
      send_item(pip_pkg::FUNC_TEST, 6'd0, '1, '1);
      send_item(pip_pkg::FUNC_TEST, 6'd0, C_MAX, '1);

      // Random phases, each with its own ring size and shape.
      for (int p = 0; p < 15; p++) begin
         if (p < 5) begin
            send_idle_pct = 23;
            rcv_idle_pct  = 66;
         end else if (p < 10) begin
            send_idle_pct = 66;
            rcv_idle_pct  = 23;
         end else begin
            send_idle_pct = 0;
            rcv_idle_pct  = 0;
         end
         cnt   = counts[p];
         n     = (cnt < MAX_VTX) ? cnt : MAX_VTX;
         shape = $urandom_range(3);
         wait_idle();
         write_count(cnt);

         // Fill every slot that the ring will read.
         for (int unsigned k = 0; k < n; k++) begin
            send_item(pip_pkg::FUNC_LOAD, pip_pkg::VINDEX_WIDTH'(k),
                      rand_coord(shape), rand_coord(shape));
         end

         for (int it = 0; it < 22; it++) begin
            if (p == 1 && it == 5) begin
               hold_request = 1'b1;
            end
            r = $urandom_range(99);
            if (r < 65) begin
               // Query point, often on a vertex y to hit the tie rules.
               if (n > 0 && $urandom_range(99) < 40) begin
                  w  = $urandom_range(n - 1);
                  qy = sb.vy[w];
                  qx = ($urandom_range(1) == 0) ? sb.vx[w] : rand_coord(shape);
               end else begin
                  qy = rand_coord(shape);
                  qx = rand_coord(shape);
               end
               send_item(pip_pkg::FUNC_TEST, pip_pkg::VINDEX_WIDTH'($urandom()), qx, qy);
            end else if (r < 90) begin
               // Move one vertex while the ring stays fully written.
               send_item(pip_pkg::FUNC_LOAD, pip_pkg::VINDEX_WIDTH'($urandom()),
                         rand_coord(shape), rand_coord(shape));
            end else begin
               send_item(pip_pkg::FUNC_TEST, pip_pkg::VINDEX_WIDTH'($urandom()),
                         $urandom(), $urandom());
            end
         end
      end

      // Drain and close the run.
      req_valid <= 1'b0;
      for (w = 0; w < 100000 && sb.pending() != 0; w++) @(posedge clock);
      repeat (DRAIN_CYC * 4) @(posedge clock);
      if (sb.pending() != 0) begin
         sb.flag($sformatf("%0d expected results never arrived", sb.pending()));
      end
      if (sb.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/pip_pkg.sv
rtl/pip_cross_unit.sv
rtl/point_in_polygon_test_unit.sv
dv/tb.sv
